// ----- hw/rtl/scatr_pkg.sv -----
// ----------------------------------------------------------------------------
// scatr_pkg
// Types and constants shared by the answer-to-reset parser modules.
// ----------------------------------------------------------------------------
package scatr_pkg;

  // Parse phase of the answer-to-reset byte sequence
  typedef enum logic [2:0] {
    PH_TS    = 3'd0,
    PH_T0    = 3'd1,
    PH_IFACE = 3'd2,
    PH_HIST  = 3'd3,
    PH_TCK   = 3'd4,
    PH_SKIP  = 3'd5
  } phase_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BAD_TS = 2'd1,
    ST_TRUNC  = 2'd2,
    ST_GROUPS = 2'd3
  } status_t;

  // Search for the first T=1 group from TD2 onward
  typedef enum logic [1:0] {
    T1_NONE = 2'd0,
    T1_CAPT = 2'd1,
    T1_DONE = 2'd2
  } t1_search_t;

  // Interface bytes captured during parsing, each with its present flag
  typedef struct packed {
    logic       ta1_vld;
    logic [7:0] ta1;
    logic       tc1_vld;
    logic [7:0] tc1;
    logic       ta2_vld;
    logic       ta2_dflt;
    logic [3:0] ta2_proto;
    logic       tc2_vld;
    logic [7:0] tc2;
    logic       td1_vld;
    logic [3:0] td1_proto;
    logic       t1_ta_vld;
    logic [7:0] t1_ta;
    logic       t1_tb_vld;
    logic [7:0] t1_tb;
    logic       t1_tc_vld;
    logic       t1_tc_crc;
  } capture_t;

  // One result item
  typedef struct packed {
    status_t    status;
    logic [3:0] fi_index;
    logic [3:0] di_index;
    logic [7:0] guard_n;
    logic [7:0] wait_wi;
    logic       spec_mode;
    logic [3:0] protocol_type;
    logic       t1_available;
    logic [7:0] t1_ifsc;
    logic [3:0] t1_cwi;
    logic [3:0] t1_bwi;
    logic       t1_edc_crc;
  } result_t;

  // Initial character codes
  localparam logic [7:0] TS_DIRECT      = 8'h3B;
  localparam logic [7:0] TS_INVERSE     = 8'h3F;
  localparam logic [7:0] TS_INVERSE_ALT = 8'h03;

  // Protocol number of T=1
  localparam logic [3:0] PROTO_T1 = 4'h1;

  // Defaults when a byte is absent, and the Fi index used in specific mode
  localparam logic [3:0] FI_DEFAULT   = 4'd1;
  localparam logic [3:0] DI_DEFAULT   = 4'd1;
  localparam logic [3:0] FI_SPECIFIC  = 4'd0;
  localparam logic [7:0] WI_DEFAULT   = 8'd10;
  localparam logic [7:0] IFSC_DEFAULT = 8'd32;
  localparam logic [3:0] CWI_DEFAULT  = 4'd13;
  localparam logic [3:0] BWI_DEFAULT  = 4'd4;

  localparam int OUT_DATA_W = 56;

endpackage

// ----- hw/rtl/smart_card_atr_parser_core.sv -----
// ----------------------------------------------------------------------------
// smart_card_atr_parser_core
// Answer-to-reset parser: walks TS, T0, the interface groups, the historical
// bytes and TCK one byte at a time and emits one result per answer.
// ----------------------------------------------------------------------------
// Pipeline: a byte is registered on acceptance and decoded in the next cycle;
//   the result for the closing byte is then stored in the output register.
// Throughput: one byte per cycle, set by the single decode stage between the
//   input register and the result register; stalls only while a result waits.
// Reset: synchronous, active low; clears the parser to expect TS, empties the
//   input and output registers. No clearing pass.
module smart_card_atr_parser_core #(
  parameter int MAX_PROTOCOLS = 7
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // [7:0] atr_byte
  input  logic                             in_tlast,   // last_byte
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [1:0] status, [5:2] fi_index, [9:6] di_index, [17:10] guard_n,
  // [25:18] wait_wi, [26] spec_mode, [30:27] protocol_type,
  // [31] t1_available, [39:32] t1_ifsc, [43:40] t1_cwi, [47:44] t1_bwi,
  // [48] t1_edc_crc, [55:49] zero
  output logic [scatr_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int GW = $clog2(MAX_PROTOCOLS + 1);
  localparam logic [GW-1:0] GRP_MAX = GW'(MAX_PROTOCOLS);
  localparam logic [GW-1:0] GRP_ONE = GW'(1);

  // Input register
  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;

  // Parser state
  scatr_pkg::phase_t     phase_r, phase_nxt;
  logic [3:0]            pend_r, pend_nxt;
  logic [GW-1:0]         grp_r, grp_nxt;
  logic [3:0]            hist_r, hist_nxt;
  logic                  cks_r, cks_nxt;
  scatr_pkg::capture_t   cap_r, cap_nxt;
  scatr_pkg::t1_search_t t1s_r, t1s_nxt;

  // Output register
  logic                  out_vld_r;
  scatr_pkg::result_t    out_res_r;

  logic                  body_end;
  logic                  done;
  logic                  emit;
  logic                  adv;
  logic                  out_free;
  scatr_pkg::status_t    err_code;
  scatr_pkg::status_t    status;
  scatr_pkg::result_t    result;

  // Datapath: field capture and counters
  always_comb begin
    pend_nxt = pend_r;
    grp_nxt  = grp_r;
    hist_nxt = hist_r;
    cks_nxt  = cks_r;
    cap_nxt  = cap_r;
    t1s_nxt  = t1s_r;
    body_end = 1'b0;
    err_code = scatr_pkg::ST_OK;

    unique case (phase_r)
      scatr_pkg::PH_TS: begin
        pend_nxt = 4'd0;
        grp_nxt  = '0;
        hist_nxt = 4'd0;
        cks_nxt  = 1'b0;
        cap_nxt  = '0;
        t1s_nxt  = scatr_pkg::T1_NONE;
        if (!(in_byte_r == scatr_pkg::TS_DIRECT || in_byte_r == scatr_pkg::TS_INVERSE ||
              in_byte_r == scatr_pkg::TS_INVERSE_ALT)) begin
          err_code = scatr_pkg::ST_BAD_TS;
        end
      end
      scatr_pkg::PH_T0: begin
        hist_nxt = in_byte_r[3:0];
        pend_nxt = in_byte_r[7:4];
        body_end = (in_byte_r[7:4] == 4'd0);
      end
      scatr_pkg::PH_IFACE: begin
        if (pend_r[0]) begin
          pend_nxt[0] = 1'b0;
          if (grp_r == '0) begin
            cap_nxt.ta1_vld = 1'b1;
            cap_nxt.ta1     = in_byte_r;
          end else if (grp_r == GRP_ONE) begin
            cap_nxt.ta2_vld   = 1'b1;
            cap_nxt.ta2_dflt  = in_byte_r[4];
            cap_nxt.ta2_proto = in_byte_r[3:0];
          end
          if (t1s_r == scatr_pkg::T1_CAPT) begin
            cap_nxt.t1_ta_vld = 1'b1;
            cap_nxt.t1_ta     = in_byte_r;
          end
        end else if (pend_r[1]) begin
          pend_nxt[1] = 1'b0;
          if (t1s_r == scatr_pkg::T1_CAPT) begin
            cap_nxt.t1_tb_vld = 1'b1;
            cap_nxt.t1_tb     = in_byte_r;
          end
        end else if (pend_r[2]) begin
          pend_nxt[2] = 1'b0;
          if (grp_r == '0) begin
            cap_nxt.tc1_vld = 1'b1;
            cap_nxt.tc1     = in_byte_r;
          end else if (grp_r == GRP_ONE) begin
            cap_nxt.tc2_vld = 1'b1;
            cap_nxt.tc2     = in_byte_r;
          end
          if (t1s_r == scatr_pkg::T1_CAPT) begin
            cap_nxt.t1_tc_vld = 1'b1;
            cap_nxt.t1_tc_crc = in_byte_r[0];
          end
        end else begin
          // TD byte: closes this group and opens the next
          pend_nxt = 4'd0;
          if (grp_r == '0) begin
            cap_nxt.td1_vld   = 1'b1;
            cap_nxt.td1_proto = in_byte_r[3:0];
          end
          if (t1s_r == scatr_pkg::T1_CAPT) begin
            t1s_nxt = scatr_pkg::T1_DONE;
          end else if (t1s_r == scatr_pkg::T1_NONE && grp_r != '0 &&
                       in_byte_r[3:0] == scatr_pkg::PROTO_T1) begin
            t1s_nxt = scatr_pkg::T1_CAPT;
          end
          cks_nxt = (in_byte_r[3:0] != 4'd0);
          if (grp_r >= GRP_MAX) begin
            err_code = scatr_pkg::ST_GROUPS;
          end else begin
            grp_nxt  = grp_r + GRP_ONE;
            pend_nxt = in_byte_r[7:4];
          end
        end
        if (err_code == scatr_pkg::ST_OK && pend_nxt == 4'd0) begin
          if (t1s_nxt == scatr_pkg::T1_CAPT) begin
            t1s_nxt = scatr_pkg::T1_DONE;
          end
          body_end = 1'b1;
        end
      end
      scatr_pkg::PH_HIST: begin
        hist_nxt = hist_r - 4'd1;
      end
      scatr_pkg::PH_TCK,
      scatr_pkg::PH_SKIP: begin
      end
      default: begin
      end
    endcase
  end

  // Completion of a well-formed answer
  always_comb begin
    unique case (phase_r)
      scatr_pkg::PH_T0,
      scatr_pkg::PH_IFACE: done = body_end && (hist_nxt == 4'd0) && !cks_nxt;
      scatr_pkg::PH_HIST:  done = (hist_nxt == 4'd0) && !cks_r;
      scatr_pkg::PH_TCK:   done = 1'b1;
      default:             done = 1'b0;
    endcase
  end

  always_comb begin
    if (err_code != scatr_pkg::ST_OK) begin
      status = err_code;
    end else if (done) begin
      status = scatr_pkg::ST_OK;
    end else begin
      status = scatr_pkg::ST_TRUNC;
    end
  end

  assign emit = (phase_r != scatr_pkg::PH_SKIP) &&
                ((err_code != scatr_pkg::ST_OK) || done || in_last_r);

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (emit || phase_r == scatr_pkg::PH_SKIP) begin
      phase_nxt = in_last_r ? scatr_pkg::PH_TS : scatr_pkg::PH_SKIP;
    end else begin
      unique case (phase_r)
        scatr_pkg::PH_TS: phase_nxt = scatr_pkg::PH_T0;
        scatr_pkg::PH_T0,
        scatr_pkg::PH_IFACE: begin
          if (!body_end) begin
            phase_nxt = scatr_pkg::PH_IFACE;
          end else if (hist_nxt != 4'd0) begin
            phase_nxt = scatr_pkg::PH_HIST;
          end else begin
            phase_nxt = scatr_pkg::PH_TCK;
          end
        end
        scatr_pkg::PH_HIST: begin
          phase_nxt = (hist_nxt == 4'd0) ? scatr_pkg::PH_TCK : scatr_pkg::PH_HIST;
        end
        default: phase_nxt = phase_r;
      endcase
    end
  end

  scatr_result u_result (
    .status (status),
    .cap    (cap_nxt),
    .t1s    (t1s_nxt),
    .result (result)
  );

  // Handshake: hold the registered byte only while its result cannot be stored
  assign out_free  = !out_vld_r || out_tready;
  assign adv       = in_vld_r && (!emit || out_free);
  assign in_tready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= scatr_pkg::PH_TS;
      pend_r  <= 4'd0;
      grp_r   <= '0;
      hist_r  <= 4'd0;
      cks_r   <= 1'b0;
      cap_r   <= '0;
      t1s_r   <= scatr_pkg::T1_NONE;
    end else if (adv) begin
      phase_r <= phase_nxt;
      pend_r  <= pend_nxt;
      grp_r   <= grp_nxt;
      hist_r  <= hist_nxt;
      cks_r   <= cks_nxt;
      cap_r   <= cap_nxt;
      t1s_r   <= t1s_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv && emit) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      out_res_r <= result;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'd0,
                       out_res_r.t1_edc_crc,
                       out_res_r.t1_bwi,
                       out_res_r.t1_cwi,
                       out_res_r.t1_ifsc,
                       out_res_r.t1_available,
                       out_res_r.protocol_type,
                       out_res_r.spec_mode,
                       out_res_r.wait_wi,
                       out_res_r.guard_n,
                       out_res_r.di_index,
                       out_res_r.fi_index,
                       out_res_r.status};

endmodule

// ----- hw/rtl/scatr_result.sv -----
// ----------------------------------------------------------------------------
// scatr_result
// Derives the result item from the captured interface bytes and the status.
// ----------------------------------------------------------------------------
module scatr_result (
  input  scatr_pkg::status_t    status,
  input  scatr_pkg::capture_t   cap,
  input  scatr_pkg::t1_search_t t1s,
  output scatr_pkg::result_t    result
);

  scatr_pkg::result_t ok_res;

  always_comb begin
    ok_res = '0;
    ok_res.status = scatr_pkg::ST_OK;

    // TA2 with bit 0x10 set selects FI_SPECIFIC and the default Di index
    if (cap.ta2_vld && cap.ta2_dflt) begin
      ok_res.fi_index = scatr_pkg::FI_SPECIFIC;
      ok_res.di_index = scatr_pkg::DI_DEFAULT;
    end else if (cap.ta1_vld) begin
      ok_res.fi_index = cap.ta1[7:4];
      ok_res.di_index = cap.ta1[3:0];
    end else begin
      ok_res.fi_index = scatr_pkg::FI_DEFAULT;
      ok_res.di_index = scatr_pkg::DI_DEFAULT;
    end

    ok_res.guard_n   = cap.tc1_vld ? cap.tc1 : 8'd0;
    ok_res.wait_wi   = cap.tc2_vld ? cap.tc2 : scatr_pkg::WI_DEFAULT;
    ok_res.spec_mode = cap.ta2_vld;

    if (cap.ta2_vld) begin
      ok_res.protocol_type = cap.ta2_proto;
    end else if (cap.td1_vld) begin
      ok_res.protocol_type = cap.td1_proto;
    end else begin
      ok_res.protocol_type = 4'd0;
    end

    ok_res.t1_available = (t1s != scatr_pkg::T1_NONE);
    ok_res.t1_ifsc      = cap.t1_ta_vld ? cap.t1_ta : scatr_pkg::IFSC_DEFAULT;
    ok_res.t1_cwi       = cap.t1_tb_vld ? cap.t1_tb[3:0] : scatr_pkg::CWI_DEFAULT;
    ok_res.t1_bwi       = cap.t1_tb_vld ? cap.t1_tb[7:4] : scatr_pkg::BWI_DEFAULT;
    ok_res.t1_edc_crc   = cap.t1_tc_vld && cap.t1_tc_crc;
  end

  // Error results carry the status alone
  always_comb begin
    if (status == scatr_pkg::ST_OK) begin
      result = ok_res;
    end else begin
      result        = '0;
      result.status = status;
    end
  end

endmodule

// ----- hw/rtl/scatr_checker.sv -----
// ----------------------------------------------------------------------------
// scatr_checker
// Port-level checks on the answer-to-reset parser, bound to the top level.
// ----------------------------------------------------------------------------
module scatr_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [scatr_pkg::OUT_DATA_W-1:0] out_tdata
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Error results carry nothing but the status
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] != 2'd0) |-> (out_tdata[55:2] == '0))
    else $error("error result with nonzero fields");

  // A fresh result follows an accepted byte request
  a_out_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result without a matching byte request");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // Padding above the last field stays zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[55:49] == 7'd0))
    else $error("result padding nonzero");

endmodule

bind smart_card_atr_parser_core scatr_checker u_scatr_checker (.*);
